// ===== sv/acd_duration_recursion_defines.svh =====
// Assertion macros shared by the duration recursion RTL.
`ifndef ACD_DURATION_RECURSION_DEFINES_SVH
`define ACD_DURATION_RECURSION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ACD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/acd_pkg.sv =====
// Package: control word, microprogram and Q16.16 helpers for the duration recursion.
`timescale 1ns / 1ps

package acd_pkg;

   // Register indexes on the csr channel
   localparam logic [3:0] REG_INTERCEPT    = 4'd0;
   localparam logic [3:0] REG_DUR_COEF_1   = 4'd1;
   localparam logic [3:0] REG_DUR_COEF_2   = 4'd2;
   localparam logic [3:0] REG_INNOV_COEF_1 = 4'd3;
   localparam logic [3:0] REG_INNOV_COEF_2 = 4'd4;
   localparam logic [3:0] REG_MEAN_COEF_1  = 4'd5;
   localparam logic [3:0] REG_MEAN_COEF_2  = 4'd6;
   localparam logic [3:0] REG_BURN_COUNT   = 4'd7;

   // Item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Multiplier operand selects
   localparam logic [2:0] MUL_NONE = 3'd0;
   localparam logic [2:0] MUL_D1   = 3'd1;
   localparam logic [2:0] MUL_D2   = 3'd2;
   localparam logic [2:0] MUL_E1   = 3'd3;
   localparam logic [2:0] MUL_E2   = 3'd4;
   localparam logic [2:0] MUL_M1   = 3'd5;
   localparam logic [2:0] MUL_M2   = 3'd6;
   localparam logic [2:0] MUL_MI   = 3'd7;

   // Accumulator operations
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd8;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [2:0] mul_sel;
      logic [1:0] acc_op;
      logic       jump_start;   // branch to STEP_FINISH on a start item
      logic       finish;       // commit results, return to idle
   } ucode_type;

   function automatic ucode_type acd_ucode(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, jump_start: 1'b0, finish: 1'b1};
      case (step)
         4'd0: uc = '{mul_sel: MUL_D1,   acc_op: ACC_LOAD, jump_start: 1'b1, finish: 1'b0};
         4'd1: uc = '{mul_sel: MUL_D2,   acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd2: uc = '{mul_sel: MUL_E1,   acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd3: uc = '{mul_sel: MUL_E2,   acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd4: uc = '{mul_sel: MUL_M1,   acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd5: uc = '{mul_sel: MUL_M2,   acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd6: uc = '{mul_sel: MUL_NONE, acc_op: ACC_ADD,  jump_start: 1'b0, finish: 1'b0};
         4'd7: uc = '{mul_sel: MUL_MI,   acc_op: ACC_HOLD, jump_start: 1'b0, finish: 1'b0};
         default: uc = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, jump_start: 1'b0, finish: 1'b1};
      endcase
      return uc;
   endfunction

   // Saturate a product already shifted down by 16 (floor)
   function automatic logic signed [31:0] sat_q48(input logic signed [47:0] q);
      logic signed [31:0] r;
      if (q[47:31] == {17{1'b0}} || q[47:31] == {17{1'b1}}) begin
         r = q[31:0];
      end else begin
         r = q[47] ? Q_MIN : Q_MAX;
      end
      return r;
   endfunction

   // Saturate the mean accumulator
   function automatic logic signed [31:0] sat_q35(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
         r = v[31:0];
      end else begin
         r = v[34] ? Q_MIN : Q_MAX;
      end
      return r;
   endfunction

endpackage

// ===== sv/acd_duration_recursion.sv =====
// Top level: microcoded ACD duration recursion with one shared Q16.16 multiplier.
//
// Usage:
//  req_*  : one transaction per item. req_tuser = kind (0 start, 1 step),
//           req_tdata = {innovation, start_mean, start_duration}, req_tlast = end of series.
//  rsp_*  : zero or one transaction per item. rsp_tdata = duration,
//           rsp_tlast = run_done. Results of the first burn_count items are dropped.
//  csr_*  : register writes (csr_index, csr_data), always ready; write only while idle.
// Sequencing: an item is taken when the sequencer is idle. A step item runs the
//  9-step microprogram (6 multiply-accumulates, mean saturation, mean x innovation,
//  commit) through the single 32x32 multiplier, and the next item is not taken
//  until this one has committed. A start item jumps straight to the commit step.
// Reset: synchronous; configuration registers, histories and the item count clear to zero.
// Stall: the result register holds while rsp_tready is low; the next item is
//  still accepted and computed, and only its commit step waits for the slot.
`timescale 1ns / 1ps
`include "acd_duration_recursion_defines.svh"

module acd_duration_recursion
   import acd_pkg::*;
#(
   parameter int DURATION_LAGS   = 2,
   parameter int INNOVATION_LAGS = 2,
   parameter int MEAN_LAGS       = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] start_duration, [63:32] start_mean,
                                    // [95:64] innovation
   input  logic [0:0]  req_tuser,   // [0] kind
   input  logic        req_tlast,
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] duration
   output logic        rsp_tlast,
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Only lags 1 and 2 carry a coefficient; deeper history never contributes.
   localparam int DUR_DEPTH  = (DURATION_LAGS > 2) ? 2 : ((DURATION_LAGS < 1) ? 1 : DURATION_LAGS);
   localparam int INN_DEPTH  = (INNOVATION_LAGS > 2) ? 2
                               : ((INNOVATION_LAGS < 1) ? 1 : INNOVATION_LAGS);
   localparam int MEAN_DEPTH = (MEAN_LAGS > 2) ? 2 : ((MEAN_LAGS < 1) ? 1 : MEAN_LAGS);
   localparam int DUR_IDX2   = (DUR_DEPTH > 1) ? 1 : 0;
   localparam int INN_IDX2   = (INN_DEPTH > 1) ? 1 : 0;
   localparam int MEAN_IDX2  = (MEAN_DEPTH > 1) ? 1 : 0;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Configuration registers
   logic signed [31:0] coef_ff [0:6];   // indexed by REG_INTERCEPT .. REG_MEAN_COEF_2
   logic [15:0]        burn_ff;

   // Histories, index 0 is the most recent
   logic signed [31:0] dur_hist_ff  [0:DUR_DEPTH-1];
   logic signed [31:0] inn_hist_ff  [0:INN_DEPTH-1];
   logic signed [31:0] mean_hist_ff [0:MEAN_DEPTH-1];
   logic [15:0]        items_seen_ff;

   // Sequencer
   logic               state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   ucode_type          uc;

   // Latched item
   logic               kind_ff, last_ff;
   logic signed [31:0] start_dur_ff, start_mean_ff, innov_ff;

   // Datapath
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic signed [31:0] prod_sat;
   logic signed [34:0] acc_ff;
   logic signed [31:0] mean_sat;

   // Commit
   logic               emit;
   logic               finish_fire;
   logic signed [31:0] dur_val, mean_val;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_last_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign uc       = acd_ucode(step_ff);
   assign prod_sat = sat_q48(prod_ff[63:16]);   // floor of product / 2^16
   assign mean_sat = sat_q35(acc_ff);

   // Operand mux; coefficients of lags beyond the configured order read as zero.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_D1: begin
            mul_a = (DURATION_LAGS >= 1) ? coef_ff[REG_DUR_COEF_1[2:0]] : '0;
            mul_b = dur_hist_ff[0];
         end
         MUL_D2: begin
            mul_a = (DURATION_LAGS >= 2) ? coef_ff[REG_DUR_COEF_2[2:0]] : '0;
            mul_b = dur_hist_ff[DUR_IDX2];
         end
         MUL_E1: begin
            mul_a = (INNOVATION_LAGS >= 1) ? coef_ff[REG_INNOV_COEF_1[2:0]] : '0;
            mul_b = inn_hist_ff[0];
         end
         MUL_E2: begin
            mul_a = (INNOVATION_LAGS >= 2) ? coef_ff[REG_INNOV_COEF_2[2:0]] : '0;
            mul_b = inn_hist_ff[INN_IDX2];
         end
         MUL_M1: begin
            mul_a = (MEAN_LAGS >= 1) ? coef_ff[REG_MEAN_COEF_1[2:0]] : '0;
            mul_b = mean_hist_ff[0];
         end
         MUL_M2: begin
            mul_a = (MEAN_LAGS >= 2) ? coef_ff[REG_MEAN_COEF_2[2:0]] : '0;
            mul_b = mean_hist_ff[MEAN_IDX2];
         end
         MUL_MI: begin
            mul_a = mean_sat;
            mul_b = innov_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Commit step values and the output-slot check
   always_comb begin
      dur_val     = (kind_ff == KIND_STEP) ? prod_sat : start_dur_ff;
      mean_val    = (kind_ff == KIND_STEP) ? mean_sat : start_mean_ff;
      emit        = (items_seen_ff >= burn_ff);
      finish_fire = (state_ff == ST_RUN) && uc.finish
                    && !(emit && rsp_valid_ff && !rsp_tready);
   end

   // Step sequencing with the start-item branch
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (uc.finish) begin
               if (finish_fire) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end
            end else if (uc.jump_start && (kind_ff == KIND_START)) begin
               step_in = STEP_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Item latch
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff       <= req_tuser[0];
         start_dur_ff  <= req_tdata[31:0];
         start_mean_ff <= req_tdata[63:32];
         innov_ff      <= req_tdata[95:64];
         last_ff       <= req_tlast;
      end
   end

   // Shared multiplier with registered product, and the mean accumulator.
   // The product holds on steps without operands, so a stalled commit keeps it.
   always_ff @(posedge clock) begin
      if (uc.mul_sel != MUL_NONE) prod_ff <= mul_a * mul_b;
      if (state_ff == ST_RUN) begin
         case (uc.acc_op)
            ACC_LOAD: acc_ff <= 35'(coef_ff[REG_INTERCEPT[2:0]]);
            ACC_ADD:  acc_ff <= acc_ff + 35'(prod_sat);
            default:  acc_ff <= acc_ff;
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 7; i++) coef_ff[i] <= '0;
         burn_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index < REG_BURN_COUNT) begin
            coef_ff[csr_index[2:0]] <= csr_data;
         end else if (csr_index == REG_BURN_COUNT) begin
            burn_ff <= csr_data[15:0];
         end
      end
   end

   // Histories and item count; cleared at reset and after the last item
   always_ff @(posedge clock) begin
      if (reset || (finish_fire && last_ff)) begin
         for (int k = 0; k < DUR_DEPTH; k++)  dur_hist_ff[k]  <= '0;
         for (int k = 0; k < INN_DEPTH; k++)  inn_hist_ff[k]  <= '0;
         for (int k = 0; k < MEAN_DEPTH; k++) mean_hist_ff[k] <= '0;
         items_seen_ff <= '0;
      end else if (finish_fire) begin
         for (int k = DUR_DEPTH - 1; k > 0; k--)  dur_hist_ff[k]  <= dur_hist_ff[k-1];
         for (int k = INN_DEPTH - 1; k > 0; k--)  inn_hist_ff[k]  <= inn_hist_ff[k-1];
         for (int k = MEAN_DEPTH - 1; k > 0; k--) mean_hist_ff[k] <= mean_hist_ff[k-1];
         dur_hist_ff[0]  <= dur_val;
         inn_hist_ff[0]  <= innov_ff;
         mean_hist_ff[0] <= mean_val;
         if (items_seen_ff != 16'hFFFF) items_seen_ff <= items_seen_ff + 16'd1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire && emit) begin
         rsp_data_ff <= dur_val;
         rsp_last_ff <= last_ff;
      end
   end

   `ACD_ASSERT_NXT(a_emit_sets_valid, clock, reset, finish_fire && emit, rsp_valid_ff, "result not registered")
   `ACD_ASSERT_NXT(a_last_clears_count, clock, reset, finish_fire && last_ff, items_seen_ff == 16'd0, "series not cleared")
   `ACD_ASSERT_IMP(a_idle_step_zero, clock, reset, state_ff == ST_IDLE, step_ff == '0, "step counter not parked")
   `ACD_ASSERT_IMP(a_step_in_range, clock, reset, state_ff == ST_RUN, step_ff <= STEP_FINISH, "step counter out of program")

endmodule

// ===== tb/sv/acd_duration_checker.sv =====
// Checker for the duration recursion: mirrors the recursion and compares every result.
`timescale 1ns / 1ps

module acd_duration_checker
   import acd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatch_count,
   output int          pending_results
);

   localparam longint Q_CEIL  = 64'sd2147483647;
   localparam longint Q_FLOOR = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic [31:0] duration;
      logic        run_done;
   } duration_result_type;

   // Register shadow
   logic signed [31:0] intercept;
   logic signed [31:0] dur_w   [2];
   logic signed [31:0] innov_w [2];
   logic signed [31:0] mean_w  [2];
   logic        [15:0] burn_count;

   // Series state
   logic signed [31:0] dur_hist   [2];
   logic signed [31:0] innov_hist [2];
   logic signed [31:0] mean_hist  [2];
   logic        [15:0] series_seen;

   duration_result_type due_durations [$];
   int errors;

   function automatic logic signed [31:0] clamp_q(input longint v);
      if (v > Q_CEIL) return Q_CEIL[31:0];
      if (v < Q_FLOOR) return Q_FLOOR[31:0];
      return v[31:0];
   endfunction

   // Q16.16 product, floor of the exact product, then clamped
   function automatic logic signed [31:0] q_product(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      longint wide;
      wide = longint'(a) * longint'(b);
      return clamp_q(wide >>> 16);
   endfunction

   always @(posedge clock) begin : monitor
      logic signed [31:0] item_mean;
      logic signed [31:0] item_dur;
      logic signed [31:0] item_innov;
      longint acc;
      duration_result_type oldest;

      if (reset) begin
         intercept   = '0;
         burn_count  = '0;
         series_seen = '0;
         for (int j = 0; j < 2; j++) begin
            dur_w[j] = '0;  innov_w[j] = '0;  mean_w[j] = '0;
            dur_hist[j] = '0;  innov_hist[j] = '0;  mean_hist[j] = '0;
         end
         due_durations.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_INTERCEPT:    intercept  = csr_data;
               REG_DUR_COEF_1:   dur_w[0]   = csr_data;
               REG_DUR_COEF_2:   dur_w[1]   = csr_data;
               REG_INNOV_COEF_1: innov_w[0] = csr_data;
               REG_INNOV_COEF_2: innov_w[1] = csr_data;
               REG_MEAN_COEF_1:  mean_w[0]  = csr_data;
               REG_MEAN_COEF_2:  mean_w[1]  = csr_data;
               REG_BURN_COUNT:   burn_count = csr_data[15:0];
               default: ;   // unmapped index, write dropped
            endcase
         end

         // compare before pushing so a result can never match its own item
         if (rsp_tvalid && rsp_tready) begin
            if (due_durations.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected result: duration %h run_done %b", rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               oldest = due_durations.pop_front();
               if (oldest.duration !== rsp_tdata || oldest.run_done !== rsp_tlast) begin
                  if (errors < REPORT_LIMIT)
                     $display("result mismatch: duration exp %h got %h, run_done exp %b got %b",
                              oldest.duration, rsp_tdata, oldest.run_done, rsp_tlast);
                  errors++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            item_innov = req_tdata[95:64];
            if (req_tuser[0] == KIND_STEP) begin
               acc = intercept;
               for (int j = 0; j < 2; j++)
                  acc += q_product(dur_w[j], dur_hist[j]) + q_product(innov_w[j], innov_hist[j])
                         + q_product(mean_w[j], mean_hist[j]);
               item_mean = clamp_q(acc);
               item_dur  = q_product(item_mean, item_innov);
            end else begin
               item_dur  = req_tdata[31:0];
               item_mean = req_tdata[63:32];
            end

            if (series_seen >= burn_count)
               due_durations.push_back('{duration: item_dur, run_done: req_tlast});

            dur_hist[1]   = dur_hist[0];    dur_hist[0]   = item_dur;
            innov_hist[1] = innov_hist[0];  innov_hist[0] = item_innov;
            mean_hist[1]  = mean_hist[0];   mean_hist[0]  = item_mean;
            if (series_seen != 16'hFFFF)
               series_seen++;

            if (req_tlast) begin
               series_seen = '0;
               for (int j = 0; j < 2; j++) begin
                  dur_hist[j] = '0;  innov_hist[j] = '0;  mean_hist[j] = '0;
               end
            end
         end
      end

      mismatch_count  <= errors;
      pending_results <= due_durations.size();
   end

endmodule

// ===== tb/sv/tb_acd_duration_recursion.sv =====
// Testbench top: drives items and register writes into the duration recursion, gives the verdict.
`timescale 1ns / 1ps

module tb_acd_duration_recursion;
   import acd_pkg::*;

   localparam int LIMIT_CYCLES  = 200_000;
   // covers a step item still in flight after the last due result, with margin
   localparam int DRAIN_CYCLES  = 24;
   // short series under the largest burn count: every item is dropped
   localparam int SOAK_ITEMS    = 12;
   localparam int PHASE_ITEMS   = 230;
   localparam int PHASE_TOTAL   = 8;
   localparam logic [3:0] REG_FIRST_UNUSED = 4'd8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;   // [31:0] start_duration, [63:32] start_mean,
                                   // [95:64] innovation
   logic [0:0]  req_tuser  = '0;   // [0] kind
   logic        req_tlast  = 1'b0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] duration
   logic        rsp_tlast;

   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;

   int mismatch_count;
   int pending_results;
   int cycle_count = 0;

   // percent of cycles the sender holds back / the receiver stalls
   int send_idle_pct = 0;
   int stall_pct     = 0;

   acd_duration_recursion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   acd_duration_checker duration_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: fresh stall decision every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_acd_duration_recursion NOT OK");
         $finish;
      end
   end

   // Mostly bounded Q16.16 values, with full-range words and the extremes mixed in
   function automatic logic [31:0] rand_q();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return $urandom;
      if (pick < 25) begin
         case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return 32'($urandom_range(0, 8 * 65536) - 4 * 65536);   // +/- 4.0
   endfunction

   // Weights: mostly inside +/- 0.6 so the recursion stays in range for a while
   function automatic logic [31:0] rand_coef();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom;
      if (pick < 15) return ($urandom_range(1) != 0) ? Q_MAX : Q_MIN;
      return 32'($urandom_range(0, 78642) - 39321);
   endfunction

   // One item transaction. Valid only drops when an idle gap is taken, so it is
   // never lowered and raised within the same step.
   task automatic send_item(input logic kind, input logic [31:0] start_dur,
                            input logic [31:0] start_mean, input logic [31:0] innov,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {innov, start_mean, start_dur};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [3:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register, then one unmapped index that must be ignored.
   // Upper bits of the burn count word are junk; only 16 bits are kept.
   task automatic load_config(input logic [31:0] icpt, input logic [31:0] d1,
                              input logic [31:0] d2, input logic [31:0] e1,
                              input logic [31:0] e2, input logic [31:0] m1,
                              input logic [31:0] m2, input logic [15:0] burn);
      write_reg(REG_INTERCEPT, icpt);
      write_reg(REG_DUR_COEF_1, d1);
      write_reg(REG_DUR_COEF_2, d2);
      write_reg(REG_INNOV_COEF_1, e1);
      write_reg(REG_INNOV_COEF_2, e2);
      write_reg(REG_MEAN_COEF_1, m1);
      write_reg(REG_MEAN_COEF_2, m2);
      write_reg(REG_BURN_COUNT, {16'($urandom), burn});
      write_reg(4'(REG_FIRST_UNUSED + $urandom_range(0, 7)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // Let the block go idle: every due result in, then time for a burn-in item
   // that produces nothing but may still be in the pipe.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random series: most open with a start item and close with end of run,
   // the rest are noise with random kind and stray end markers.
   task automatic run_phase(input int item_total);
      int   sent;
      int   len;
      bit   tidy;
      logic kind;
      logic last;
      logic [31:0] innov;
      sent = 0;
      while (sent < item_total) begin
         len  = ($urandom_range(99) < 20) ? $urandom_range(1, 4) : $urandom_range(5, 40);
         tidy = ($urandom_range(99) < 85);
         for (int k = 0; k < len; k++) begin
            if (tidy) begin
               kind  = (k == 0 || $urandom_range(99) < 4) ? KIND_START : KIND_STEP;
               last  = (k == len - 1);
               // innovations are mostly positive and near one, like real ones
               innov = ($urandom_range(99) < 80) ? 32'($urandom_range(0, 3 * 65536)) : rand_q();
            end else begin
               kind  = 1'($urandom_range(1));
               last  = ($urandom_range(99) < 8);
               innov = rand_q();
            end
            send_item(kind, rand_q(), rand_q(), innov, last);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: moderate weights, field extremes, rounding, series end ----
      load_config(32'h0001_0000, 32'h0000_4000, 32'hFFFF_E000, 32'h0000_8000,
                  32'hFFFF_0000, 32'h0000_8000, 32'h0000_2000, 16'd0);
      send_item(KIND_START, Q_MAX, Q_MAX, Q_MAX, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, Q_MAX, 1'b0);          // product clamps high
      send_item(KIND_STEP, 32'h0, 32'h0, Q_MIN, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(KIND_START, Q_MIN, Q_MIN, Q_MIN, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, Q_MIN, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);  // floor on negative product
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0000_0001, 1'b1);  // series end clears history
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0001_0000, 1'b0);  // fresh series: mean = intercept
      send_item(KIND_START, 32'h1234_5678, 32'h8765_4321, 32'h0000_8000, 1'b1);
      settle();

      // all weights at the top: mean sum clamps high
      load_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'd0);
      send_item(KIND_START, Q_MAX, Q_MAX, Q_MAX, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, Q_MAX, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, Q_MIN, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0000_0001, 1'b1);
      settle();

      // all weights at the bottom, first two items burned
      load_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'd2);
      send_item(KIND_START, Q_MIN, Q_MIN, Q_MIN, 1'b0);
      send_item(KIND_STEP, Q_MAX, Q_MAX, Q_MIN, 1'b0);
      send_item(KIND_STEP, Q_MAX, Q_MAX, Q_MAX, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
      settle();

      // series that ends inside its burn-in: no result, no run_done
      load_config(32'h0000_8000, 32'h0000_4000, 32'h0000_2000, 32'h0000_4000,
                  32'h0000_2000, 32'h0000_4000, 32'h0000_2000, 16'd3);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0002_0000, 1'b1);
      send_item(KIND_START, 32'h0003_0000, 32'h0002_0000, 32'h0001_8000, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0000_C000, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0001_4000, 1'b0);
      send_item(KIND_STEP, 32'h0, 32'h0, 32'h0000_4000, 1'b1);
      settle();

      // ---- short series under the largest burn count: nothing comes out ----
      load_config(rand_q(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef(), 16'hFFFF);
      for (int k = 0; k < SOAK_ITEMS; k++)
         send_item(KIND_START, $urandom, $urandom, $urandom, k == SOAK_ITEMS - 1);
      settle();

      // ---- random phases, cycling through the idle/stall mixes ----
      for (int p = 0; p < PHASE_TOTAL; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         if (p == 3)
            load_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'd0);
         else if (p == 6)
            load_config(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'd1);
         else
            load_config(rand_q(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                        rand_coef(), rand_coef(), (p == 0) ? 16'd0 : 16'($urandom_range(0, 6)));
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb_acd_duration_recursion OK");
      end else begin
         $display("tb_acd_duration_recursion NOT OK");
      end
      $finish;
   end

endmodule
